[hdl/i2p_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared sizes, codes and types for the infix to postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int MAX_RESULTS = STACK_DEPTH + 1;
   localparam int RB_IDX_W    = $clog2(MAX_RESULTS);
   localparam int RB_CNT_W    = $clog2(MAX_RESULTS + 1);

   // stack entry codes
   localparam logic [2:0] CODE_ADD    = 3'd0;
   localparam logic [2:0] CODE_SUB    = 3'd1;
   localparam logic [2:0] CODE_MUL    = 3'd2;
   localparam logic [2:0] CODE_DIV    = 3'd3;
   localparam logic [2:0] CODE_LPAREN = 3'd4;
   localparam logic [2:0] CODE_LBRACK = 3'd5;

   // status codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_BRACKET  = 2'd2;
   localparam logic [1:0] ERR_UNKNOWN  = 2'd3;

   // one postfix character from the engine into the result buffer
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } emit_type;

   // end of work on one request
   typedef struct packed {
      logic       valid;
      logic [1:0] err;
      logic       last;
   } done_type;

   function automatic logic [7:0] code_char(input logic [2:0] code);
      logic [7:0] c;
      case (code)
         CODE_ADD:    c = 8'h2B;
         CODE_SUB:    c = 8'h2D;
         CODE_MUL:    c = 8'h2A;
         CODE_DIV:    c = 8'h2F;
         CODE_LPAREN: c = 8'h28;
         CODE_LBRACK: c = 8'h5B;
         default:     c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] prio(input logic [2:0] code);
      logic [2:0] p;
      case (code)
         CODE_ADD, CODE_SUB: p = 3'd4;
         CODE_MUL, CODE_DIV: p = 3'd5;
         default:            p = 3'd3;
      endcase
      return p;
   endfunction

   function automatic logic [1:0] first_err(input logic [1:0] cur, input logic [1:0] e);
      return (cur == ERR_NONE) ? e : cur;
   endfunction

endpackage
`default_nettype wire

[hdl/i2p_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_req_if / i2p_rsp_if
// Valid/ready channels for infix characters in and postfix results out.
// ----------------------------------------------------------------------------
interface i2p_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;

   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface i2p_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_valid;
   logic       out_last;
   logic       out_expr_end;
   logic [1:0] out_error;

   modport source (output valid, output out_char, output out_valid, output out_last,
                   output out_expr_end, output out_error, input ready);
   modport sink   (input valid, input out_char, input out_valid, input out_last,
                   input out_expr_end, input out_error, output ready);
endinterface
`default_nettype wire

[hdl/i2p_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_engine
// Shunting-yard engine: operator stack in a synchronous RAM, one stack entry
// examined per cycle, postfix characters handed out as they are popped.
// ----------------------------------------------------------------------------
module i2p_engine (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               free,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_char,
   input  wire logic               req_last,
   output i2p_pkg::emit_type       emit,
   output i2p_pkg::done_type       done
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_OPER  = 2'd1;
   localparam logic [1:0] S_CLOSE = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;

   localparam logic [i2p_pkg::CNT_W-1:0] CNT_ONE  = i2p_pkg::CNT_W'(1);
   localparam logic [i2p_pkg::CNT_W-1:0] CNT_FULL = i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH);

   logic [2:0]                 stack_mem [i2p_pkg::STACK_DEPTH];

   logic [1:0]                 state_ff, state_in;
   logic [i2p_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [2:0]                 op_ff, op_in;
   logic                       last_ff, last_in;
   logic [1:0]                 err_ff, err_in;
   logic [2:0]                 top_ff;

   logic                       accept;
   logic                       char_done;
   logic                       wr_en;
   logic [2:0]                 wr_data;
   logic [i2p_pkg::SP_W-1:0]   wr_addr;
   logic [i2p_pkg::CNT_W-1:0]  rd_ptr;
   logic [i2p_pkg::SP_W-1:0]   rd_addr;
   logic                       is_letter;
   logic                       pop_ok;

   assign req_ready = (state_ff == S_IDLE) && free;
   assign accept    = req_valid && req_ready;
   assign is_letter = ((req_char >= CH_LO_A) && (req_char <= CH_LO_Z)) ||
                      ((req_char >= CH_UP_A) && (req_char <= CH_UP_Z));
   assign pop_ok    = (cnt_ff != '0) && (top_ff < i2p_pkg::CODE_LPAREN) &&
                      (i2p_pkg::prio(top_ff) >= i2p_pkg::prio(op_ff));

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      op_in      = op_ff;
      last_in    = last_ff;
      err_in     = err_ff;
      wr_en      = 1'b0;
      wr_data    = op_ff;
      emit.valid = 1'b0;
      emit.data  = i2p_pkg::code_char(top_ff);
      char_done  = 1'b0;
      done.valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in = req_last;
               err_in  = i2p_pkg::ERR_NONE;
               if (is_letter) begin
                  emit.valid = 1'b1;
                  emit.data  = req_char;
                  char_done  = 1'b1;
               end else begin
                  case (req_char)
                     CH_PLUS: begin
                        op_in    = i2p_pkg::CODE_ADD;
                        state_in = S_OPER;
                     end
                     CH_MINUS: begin
                        op_in    = i2p_pkg::CODE_SUB;
                        state_in = S_OPER;
                     end
                     CH_STAR: begin
                        op_in    = i2p_pkg::CODE_MUL;
                        state_in = S_OPER;
                     end
                     CH_SLASH: begin
                        op_in    = i2p_pkg::CODE_DIV;
                        state_in = S_OPER;
                     end
                     CH_LPAREN, CH_LBRACK: begin
                        wr_data   = (req_char == CH_LPAREN) ? i2p_pkg::CODE_LPAREN
                                                            : i2p_pkg::CODE_LBRACK;
                        char_done = 1'b1;
                        if (cnt_ff < CNT_FULL) begin
                           wr_en  = 1'b1;
                           cnt_in = cnt_ff + CNT_ONE;
                        end else begin
                           err_in = i2p_pkg::ERR_OVERFLOW;
                        end
                     end
                     CH_RPAREN: begin
                        op_in    = i2p_pkg::CODE_LPAREN;
                        state_in = S_CLOSE;
                     end
                     CH_RBRACK: begin
                        op_in    = i2p_pkg::CODE_LBRACK;
                        state_in = S_CLOSE;
                     end
                     default: begin
                        err_in    = i2p_pkg::ERR_UNKNOWN;
                        char_done = 1'b1;
                     end
                  endcase
               end
            end
         end
         S_OPER: begin
            if (pop_ok) begin
               emit.valid = 1'b1;
               cnt_in     = cnt_ff - CNT_ONE;
            end else begin
               char_done = 1'b1;
               if (cnt_ff < CNT_FULL) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + CNT_ONE;
               end else begin
                  err_in = i2p_pkg::first_err(err_ff, i2p_pkg::ERR_OVERFLOW);
               end
            end
         end
         S_CLOSE: begin
            if (cnt_ff == '0) begin
               err_in    = i2p_pkg::first_err(err_ff, i2p_pkg::ERR_BRACKET);
               char_done = 1'b1;
            end else if (top_ff >= i2p_pkg::CODE_LPAREN) begin
               char_done = 1'b1;
               if (top_ff == op_ff) begin
                  cnt_in = cnt_ff - CNT_ONE;
               end else begin
                  err_in = i2p_pkg::first_err(err_ff, i2p_pkg::ERR_BRACKET);
               end
            end else begin
               emit.valid = 1'b1;
               cnt_in     = cnt_ff - CNT_ONE;
            end
         end
         S_FLUSH: begin
            if (cnt_ff == '0) begin
               state_in   = S_IDLE;
               done.valid = 1'b1;
            end else begin
               // stray opener is dropped
               if (top_ff >= i2p_pkg::CODE_LPAREN) begin
                  err_in = i2p_pkg::first_err(err_ff, i2p_pkg::ERR_BRACKET);
               end else begin
                  emit.valid = 1'b1;
               end
               cnt_in = cnt_ff - CNT_ONE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (char_done) begin
         if (last_in) begin
            state_in = S_FLUSH;
         end else begin
            state_in   = S_IDLE;
            done.valid = 1'b1;
         end
      end

      done.err  = err_in;
      done.last = last_in;
   end

   // read always targets the top of the stack as it will be next cycle
   assign wr_addr = cnt_ff[i2p_pkg::SP_W-1:0];
   assign rd_ptr  = cnt_in - CNT_ONE;
   assign rd_addr = rd_ptr[i2p_pkg::SP_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         top_ff <= wr_data;
      end else begin
         top_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
         err_ff   <= i2p_pkg::ERR_NONE;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("stack count beyond depth");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (cnt_ff < CNT_FULL))
      else $error("push into full stack");

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done.valid |=> (state_ff == S_IDLE))
      else $error("engine not idle after done");

   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      (emit.valid && (state_ff != S_IDLE)) |=> (cnt_ff == $past(cnt_ff) - CNT_ONE))
      else $error("emitted operator without pop");

endmodule
`default_nettype wire

[hdl/infix_to_postfix_converter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard infix to postfix conversion, one character per request.
// ----------------------------------------------------------------------------
// Steps: the request is taken, then the engine scans its stack (each pop or
//   dropped opener, a step to end an operator or closer scan, a step to see
//   the empty stack on a flush), then each result loads into the output register.
// Throughput: one request at a time, the next taken the cycle after the last
//   result loads.
// Reset: synchronous; stack, result buffer and output register empty; RAMs kept.
module infix_to_postfix_converter (
   input  wire logic     clock,
   input  wire logic     reset,
   i2p_req_if.sink       req_chan,
   i2p_rsp_if.source     rsp_chan
);

   localparam logic [i2p_pkg::RB_CNT_W-1:0] RB_ONE = i2p_pkg::RB_CNT_W'(1);

   // result buffer: characters of the current request, drained after the
   // request's status code is final (an error can turn up after some output)
   logic [7:0]                    rbuf_mem [i2p_pkg::MAX_RESULTS];

   i2p_pkg::emit_type             emit;
   i2p_pkg::done_type             done;

   logic                          drain_ff, drain_in;
   logic [i2p_pkg::RB_CNT_W-1:0]  nres_ff, nres_in;
   logic [i2p_pkg::RB_CNT_W-1:0]  rix_ff, rix_in;
   logic [1:0]                    err_ff, err_in;
   logic                          last_ff, last_in;
   logic [7:0]                    rbuf_rd_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    out_char_ff;
   logic                          out_valid_ff;
   logic                          out_last_ff;
   logic                          out_expr_end_ff;
   logic [1:0]                    out_error_ff;

   logic                          load;
   logic                          final_res;
   logic                          no_chars;
   logic [i2p_pkg::RB_IDX_W-1:0]  rb_wr_addr;
   logic [i2p_pkg::RB_IDX_W-1:0]  rb_rd_addr;

   i2p_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .free      (!drain_ff),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_char  (req_chan.in_char),
      .req_last  (req_chan.in_last),
      .emit      (emit),
      .done      (done)
   );

   // while draining, the output register loads whenever it is empty or being taken
   assign load      = drain_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign no_chars  = (nres_ff == '0);
   assign final_res = no_chars || ((rix_ff + RB_ONE) == nres_ff);

   always_comb begin
      drain_in     = drain_ff;
      nres_in      = nres_ff;
      rix_in       = rix_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (emit.valid) begin
         nres_in = nres_ff + RB_ONE;
      end

      if (done.valid) begin
         drain_in = 1'b1;
         err_in   = done.err;
         last_in  = done.last;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
         if (final_res) begin
            drain_in = 1'b0;
            nres_in  = '0;
            rix_in   = '0;
         end else begin
            rix_in = rix_ff + RB_ONE;
         end
      end
   end

   assign rb_wr_addr = nres_ff[i2p_pkg::RB_IDX_W-1:0];
   assign rb_rd_addr = rix_in[i2p_pkg::RB_IDX_W-1:0];

   // read-ahead of the next result; forward a same-cycle write
   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rbuf_mem[rb_wr_addr] <= emit.data;
      end
      if (emit.valid && (rb_wr_addr == rb_rd_addr)) begin
         rbuf_rd_ff <= emit.data;
      end else begin
         rbuf_rd_ff <= rbuf_mem[rb_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff     <= 1'b0;
         nres_ff      <= '0;
         rix_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         drain_ff     <= drain_in;
         nres_ff      <= nres_in;
         rix_ff       <= rix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff  <= err_in;
      last_ff <= last_in;
      if (load) begin
         // no characters: one status-only result
         out_char_ff     <= no_chars ? 8'h00 : rbuf_rd_ff;
         out_valid_ff    <= !no_chars;
         out_last_ff     <= final_res;
         out_expr_end_ff <= final_res && last_ff;
         out_error_ff    <= err_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_char     = out_char_ff;
   assign rsp_chan.out_valid    = out_valid_ff;
   assign rsp_chan.out_last     = out_last_ff;
   assign rsp_chan.out_expr_end = out_expr_end_ff;
   assign rsp_chan.out_error    = out_error_ff;

   a_done_when_free : assert property (@(posedge clock) disable iff (reset)
      (done.valid || emit.valid) |-> !drain_ff)
      else $error("engine worked while buffer drains");

   a_buf_room : assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> (nres_ff < i2p_pkg::RB_CNT_W'(i2p_pkg::MAX_RESULTS)))
      else $error("result buffer overrun");

   a_final_ends_drain : assert property (@(posedge clock) disable iff (reset)
      (load && final_res) |=> (!drain_ff && (nres_ff == '0)))
      else $error("drain did not close after last result");

   a_ready_after_drain : assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !drain_ff)
      else $error("request taken during drain");

endmodule
`default_nettype wire

[bench/infix_to_postfix_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_checker
// Watches the request and result channels, works out the postfix output of
// every accepted request and compares each result, in order, field by field.
// ----------------------------------------------------------------------------
module infix_to_postfix_checker (
   input  logic clock,
   input  logic reset,
   i2p_req_if   req_mon,
   i2p_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   checked,
   output int   flagged
);

   typedef struct packed {
      logic [7:0] glyph;
      logic       glyph_valid;
      logic       is_last;
      logic       expr_end;
      logic [1:0] err;
   } postfix_result_t;

   postfix_result_t postfix_q[$];

   // shadow of the operator stack
   logic [2:0] op_stack [i2p_pkg::STACK_DEPTH];
   int         stack_fill;

   // scratch for the request being worked out
   logic [7:0] emitted[$];
   logic [1:0] req_err;

   postfix_result_t want;

   function automatic int rank(input logic [2:0] code);
      case (code)
         i2p_pkg::CODE_ADD, i2p_pkg::CODE_SUB: return 4;
         i2p_pkg::CODE_MUL, i2p_pkg::CODE_DIV: return 5;
         default:                              return 3;
      endcase
   endfunction

   function automatic logic [7:0] symbol(input logic [2:0] code);
      case (code)
         i2p_pkg::CODE_ADD: return "+";
         i2p_pkg::CODE_SUB: return "-";
         i2p_pkg::CODE_MUL: return "*";
         i2p_pkg::CODE_DIV: return "/";
         default:           return 8'h00;
      endcase
   endfunction

   // first error found in a request wins
   function automatic void flag_error(input logic [1:0] e);
      if (req_err == i2p_pkg::ERR_NONE)
         req_err = e;
   endfunction

   function automatic void pop_to_output();
      emitted.push_back(symbol(op_stack[stack_fill - 1]));
      stack_fill--;
   endfunction

   function automatic void predict_request(input logic [7:0] ch, input logic flush);
      logic [2:0]      code;
      logic            do_push;
      postfix_result_t r;
      emitted.delete();
      req_err = i2p_pkg::ERR_NONE;
      do_push = 1'b0;
      code    = i2p_pkg::CODE_ADD;
      if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) begin
         emitted.push_back(ch);
      end else begin
         case (ch)
            "+", "-", "*", "/": begin
               code = (ch == "+") ? i2p_pkg::CODE_ADD : (ch == "-") ? i2p_pkg::CODE_SUB :
                      (ch == "*") ? i2p_pkg::CODE_MUL : i2p_pkg::CODE_DIV;
               while (stack_fill > 0 && op_stack[stack_fill - 1] < i2p_pkg::CODE_LPAREN &&
                      rank(op_stack[stack_fill - 1]) >= rank(code))
                  pop_to_output();
               do_push = 1'b1;
            end
            "(", "[": begin
               code    = (ch == "(") ? i2p_pkg::CODE_LPAREN : i2p_pkg::CODE_LBRACK;
               do_push = 1'b1;
            end
            ")", "]": begin
               code = (ch == ")") ? i2p_pkg::CODE_LPAREN : i2p_pkg::CODE_LBRACK;
               while (stack_fill > 0 && op_stack[stack_fill - 1] < i2p_pkg::CODE_LPAREN)
                  pop_to_output();
               // empty stack or wrong opener: closer dropped, stack kept
               if (stack_fill == 0 || op_stack[stack_fill - 1] != code)
                  flag_error(i2p_pkg::ERR_BRACKET);
               else
                  stack_fill--;
            end
            default: flag_error(i2p_pkg::ERR_UNKNOWN);
         endcase
      end

      if (do_push) begin
         if (stack_fill < i2p_pkg::STACK_DEPTH) begin
            op_stack[stack_fill] = code;
            stack_fill++;
         end else begin
            flag_error(i2p_pkg::ERR_OVERFLOW);
         end
      end

      if (flush) begin
         while (stack_fill > 0) begin
            if (op_stack[stack_fill - 1] >= i2p_pkg::CODE_LPAREN) begin
               flag_error(i2p_pkg::ERR_BRACKET);
               stack_fill--;
            end else begin
               pop_to_output();
            end
         end
      end

      // a request that emits nothing still answers with one status result
      if (emitted.size() == 0) begin
         r = '0;
         r.err      = req_err;
         r.is_last  = 1'b1;
         r.expr_end = flush;
         postfix_q.push_back(r);
      end else begin
         foreach (emitted[i]) begin
            r.glyph       = emitted[i];
            r.glyph_valid = 1'b1;
            r.err         = req_err;
            r.is_last     = (i == emitted.size() - 1);
            r.expr_end    = r.is_last && flush;
            postfix_q.push_back(r);
         end
      end
   endfunction

   task automatic check_field(input string field, input logic [7:0] exp_val,
                              input logic [7:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", field, exp_val, got_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stack_fill = 0;
         postfix_q.delete();
         fail_count = 0;
         checked    = 0;
         flagged    = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_request(req_mon.in_char, req_mon.in_last);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (postfix_q.size() == 0) begin
               $error("result with nothing expected: out_char %0h out_valid %0b",
                      rsp_mon.out_char, rsp_mon.out_valid);
               fail_count++;
            end else begin
               want = postfix_q.pop_front();
               check_field("out_char", want.glyph, rsp_mon.out_char);
               check_field("out_valid", want.glyph_valid, rsp_mon.out_valid);
               check_field("out_last", want.is_last, rsp_mon.out_last);
               check_field("out_expr_end", want.expr_end, rsp_mon.out_expr_end);
               check_field("out_error", want.err, rsp_mon.out_error);
               checked++;
               if (want.err != i2p_pkg::ERR_NONE)
                  flagged++;
            end
         end
      end
      pending = postfix_q.size();
   end

endmodule

[bench/infix_to_postfix_converter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb
// Feeds infix text to the converter one character per request: a directed
// opening, then random expressions, deep nesting, broken text and noise,
// with random gaps and stalls on both channels. The checker does the scoring.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;

   localparam int HALF_PERIOD    = 6;
   localparam int TOTAL_REQUESTS = 480;
   // worst case per request: a gap, the engine scan and up to 17 results, each
   // behind a stall; the limit covers TOTAL_REQUESTS of those
   localparam int CYCLE_LIMIT    = 500000;

   logic clock = 1'b0;
   logic reset;

   i2p_req_if req_chan ();
   i2p_rsp_if rsp_chan ();

   int fail_count;
   int pending;
   int checked;
   int flagged;

   int sent_count  = 0;
   int cycle_count = 0;
   bit quiet_spell = 1'b0;   // when set, neither side idles

   logic [7:0] text_q[$];    // characters waiting to be sent

   always #(HALF_PERIOD) clock = ~clock;

   infix_to_postfix_converter i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   infix_to_postfix_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .flagged    (flagged)
   );

   // Watchdog: a hung converter ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
         $display("infix_to_postfix_converter_tb: FAIL");
         $finish;
      end
   end

   // Result side: before each result, hold ready low for a random number of
   // cycles, then keep it high until a result is taken.
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = quiet_spell ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   end

   // One request. Called at a falling edge, returns at a falling edge. With
   // no gap, valid simply stays high and the next character follows at once.
   task automatic send_char(input logic [7:0] ch, input logic flush);
      int gap;
      gap = quiet_spell ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_char <= ch;
      req_chan.in_last <= flush;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
      sent_count++;
   endtask

   // Sends everything queued; the last flag rides on the final character only
   // if asked, so unterminated text leaves the stack loaded for what follows.
   task automatic send_text(input bit flush_at_end);
      logic [7:0] ch;
      while (text_q.size() > 0) begin
         ch = text_q.pop_front();
         send_char(ch, flush_at_end && text_q.size() == 0);
      end
   endtask

   function automatic void queue_string(input string s);
      for (int i = 0; i < s.len(); i++)
         text_q.push_back(s[i]);
   endfunction

   function automatic logic [7:0] random_letter();
      logic [7:0] base;
      base = $urandom_range(0, 1) ? "a" : "A";
      return 8'(base + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_operator();
      string ops;
      ops = "+-*/";
      return ops[$urandom_range(0, 3)];
   endfunction

   // Well-formed expression: operands and operators alternate, brackets of
   // both kinds nest up to six deep and are always closed in order.
   function automatic void build_expression();
      logic [7:0] closers[$];
      int         terms;
      bit         want_operand;
      bit         done;
      terms        = $urandom_range(1, 7);
      want_operand = 1'b1;
      done         = 1'b0;
      while (!done) begin
         if (want_operand) begin
            if (closers.size() < 6 && $urandom_range(0, 3) == 0) begin
               if ($urandom_range(0, 1)) begin
                  text_q.push_back("(");
                  closers.push_back(")");
               end else begin
                  text_q.push_back("[");
                  closers.push_back("]");
               end
            end else begin
               text_q.push_back(random_letter());
               terms--;
               want_operand = 1'b0;
            end
         end else if (closers.size() > 0 && (terms <= 0 || $urandom_range(0, 2) == 0)) begin
            text_q.push_back(closers.pop_back());
         end else if (terms > 0) begin
            text_q.push_back(random_operator());
            want_operand = 1'b1;
         end else begin
            done = 1'b1;
         end
      end
   endfunction

   // Nesting of 12 to 20 levels, often enough to overrun the 16-entry stack.
   // Operators inside the nest also take slots. Half the time the brackets are closed again.
   function automatic void build_deep_nest();
      logic [7:0] closers[$];
      int         levels;
      levels = $urandom_range(12, 20);
      for (int i = 0; i < levels; i++) begin
         if ($urandom_range(0, 1)) begin
            text_q.push_back("(");
            closers.push_back(")");
         end else begin
            text_q.push_back("[");
            closers.push_back("]");
         end
         if ($urandom_range(0, 3) == 0) begin
            text_q.push_back(random_letter());
            text_q.push_back(random_operator());
         end
      end
      text_q.push_back(random_letter());
      if ($urandom_range(0, 1))
         while (closers.size() > 0)
            text_q.push_back(closers.pop_back());
   endfunction

   // Broken text: bracket, operator, letter and unknown characters at random.
   function automatic void build_broken();
      string      tokens;
      int         len;
      int         pick;
      logic [7:0] ch;
      tokens = "()[]+-*/";
      len    = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5)
            ch = tokens[$urandom_range(0, 7)];
         else if (pick < 9)
            ch = random_letter();
         else
            ch = 8'($urandom_range(0, 255));
         text_q.push_back(ch);
      end
   endfunction

   initial begin
      int pick;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.in_char = 8'h00;
      req_chan.in_last = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening.
      // Every operator, both bracket kinds, and an equal-priority pop when
      // '/' meets the stacked '*'.
      queue_string("a*[b-c]/(y+Z)");
      send_text(1'b1);
      // closer on an empty stack
      queue_string(")");
      send_text(1'b0);
      // closer meeting the other kind of opener, then that opener at flush
      queue_string("(A]z");
      send_text(1'b1);
      // unknown characters at both ends of the byte range, flush of an
      // empty stack
      text_q.push_back(8'h00);
      text_q.push_back(8'hFF);
      send_text(1'b1);
      // left to right at equal priority
      queue_string("p-q+r");
      send_text(1'b1);

      // Random part: mostly well-formed expressions, the rest deep nesting,
      // broken text and single noise bytes. About a quarter of the rounds run
      // with no idling on either side.
      while (sent_count < TOTAL_REQUESTS) begin
         quiet_spell = ($urandom_range(0, 3) == 0);
         pick        = $urandom_range(0, 99);
         if (pick < 70) begin
            build_expression();
            send_text(1'b1);
         end else if (pick < 80) begin
            build_deep_nest();
            send_text(1'b1);
         end else if (pick < 92) begin
            build_broken();
            send_text(1'($urandom_range(0, 1)));
         end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
            send_text(1'($urandom_range(0, 1)));
         end
      end
      quiet_spell = 1'b0;
      req_chan.valid <= 1'b0;

      // Drain: every request answers with at least one result, so once
      // nothing is due the converter is idle; a further wait catches strays.
      while (pending != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d requests of infix text; %0d postfix results checked,",
               sent_count, checked);
      $display("%0d of them with an error code.", flagged);
      if (fail_count == 0) begin
         $display("infix_to_postfix_converter_tb: PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("infix_to_postfix_converter_tb: FAIL");
      end
      $finish;
   end

endmodule
